>>> src/sprite_frame_sequencer_unit_assert.svh
// Assertion macros for the sprite frame sequencer unit.
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SFS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfs: same-cycle check failed");
`define SFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfs: next-cycle check failed");
`else
`define SFS_ASSERT_SAME(name, clk, rst, ante, cons)
`define SFS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> src/sfs_pkg.sv
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

   // Storage geometry
   localparam int NUM_SETS   = 8;
   localparam int SET_DEPTH  = 64;
   localparam int FRAME_BITS = 10;
   localparam int SET_BITS   = 3;
   localparam int POS_BITS   = 6;
   localparam int LEN_BITS   = 7;
   localparam int ADDR_BITS  = SET_BITS + POS_BITS;

   // Shared divider widths
   localparam int DIV_W     = 17;
   localparam int DIVISOR_W = 16;
   localparam int DIV_CNT_W = 5;

   // Register indexes of the csr port
   localparam logic [2:0] REG_FRAME_PERIOD  = 3'd0;
   localparam logic [2:0] REG_ACTIVE_SET    = 3'd1;
   localparam logic [2:0] REG_SHEET_COLUMNS = 3'd2;
   localparam logic [2:0] REG_SHEET_ROWS    = 3'd3;
   localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
   localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;

   // Request modes
   localparam logic [1:0] MODE_ADVANCE = 2'd0;
   localparam logic [1:0] MODE_DRAW    = 2'd1;
   localparam logic [1:0] MODE_SET_POS = 2'd2;
   localparam logic [1:0] MODE_WRITE   = 2'd3;

   typedef struct packed {
      logic [1:0]            mode;
      logic [15:0]           time_step;
      logic [FRAME_BITS-1:0] frame_number;
      logic [SET_BITS-1:0]   set_number;
      logic [POS_BITS-1:0]   position;
      logic                  is_last;
   } req_type;

   typedef struct packed {
      logic [19:0]           sheet_x;
      logic [19:0]           sheet_y;
      logic [FRAME_BITS-1:0] frame_shown;
      logic [POS_BITS-1:0]   position_now;
      logic                  advanced;
   } rsp_type;

   // Divider command and status
   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] nbits;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_W-1:0]     quotient;
      logic [DIVISOR_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> src/sfs_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module sfs_div (
   input  logic                clock,
   input  logic                reset,
   input  sfs_pkg::div_req_type div_req,
   output sfs_pkg::div_rsp_type div_rsp
);
   import sfs_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_W-1:0]     dvd_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] dsr_ff;

   logic [DIV_W-1:0]     trial;
   logic [DIV_W-1:0]     diff;
   logic                 fits;
   logic [DIVISOR_W-1:0] rem_in;

   // One restoring step
   always_comb begin
      trial  = {rem_ff, dvd_ff[DIV_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= div_req.nbits;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath; dividend is left-aligned so only nbits steps are needed
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= DIV_W'(div_req.dividend << (DIV_CNT_W'(DIV_W) - div_req.nbits));
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> src/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer: animation state, frame set memory and sheet offsets.
//
// Requests come in on req_valid/req_stall with a req_data transaction; each
// one yields exactly one rsp_data transaction on rsp_valid/rsp_stall. The
// csr_ port writes the six setup registers and may only be used while idle.
// One request is worked on at a time; req_stall is high while it is in work.
// Steps per request:
//   set position / write entry: straight to the result
//   draw tile: 10-bit divide by sheet_columns, skipped with zero columns
//   advance: lookup, memory read and 10-bit divide without a frame change;
//   when the frame changes, first a 17-bit modulo of elapsed time and a
//   7-bit wrap of the set position, then lookup and offset divide.
// The next request can be taken in the same cycle that rsp_valid rises. All
// divisions share one restoring divider that retires one quotient bit per
// cycle; it sets the pace. The frame set table is a 512 x 10 synchronous
// memory whose registered read feeds the frame select. A finished result
// waits in work while the result register is stalled. Reset clears state,
// elapsed time, position, set lengths and setup registers (sheet columns and
// rows go to 1); the frame set memory keeps its contents and must be written first.
module sprite_frame_sequencer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfs_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import sfs_pkg::*;

   `include "sprite_frame_sequencer_unit_assert.svh"

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EMOD  = 7'b0000010,
      S_PMOD  = 7'b0000100,
      S_LOOK  = 7'b0001000,
      S_FRAME = 7'b0010000,
      S_FDIV  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Setup registers
   logic [15:0]           frame_period_ff;
   logic [SET_BITS-1:0]   active_set_ff;
   logic [9:0]            sheet_columns_ff;
   logic [9:0]            sheet_rows_ff;
   logic [9:0]            frame_width_ff;
   logic [9:0]            frame_height_ff;

   // Animation state
   logic [DIV_W-1:0]      elapsed_ff;
   logic [POS_BITS-1:0]   set_position_ff;
   logic [LEN_BITS-1:0]   set_length_ff [NUM_SETS];
   logic [FRAME_BITS-1:0] set_mem [NUM_SETS*SET_DEPTH];
   logic [FRAME_BITS-1:0] mem_rd_ff;

   // Per-transaction work registers
   logic [LEN_BITS-1:0]   len_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic [19:0]           res_x_ff;
   logic [19:0]           res_y_ff;
   logic                  adv_ff;

   // Result register
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  accept;
   logic                  out_free;
   logic [DIV_W:0]        sum_wide;
   logic [DIV_W-1:0]      sum;
   logic                  do_step;
   logic                  over;
   logic [19:0]           area;
   logic [LEN_BITS-1:0]   len_now;
   logic [FRAME_BITS-1:0] frame_sel;
   logic [LEN_BITS-1:0]   pos_inc;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_wa;
   logic [ADDR_BITS-1:0]  mem_ra;

   sfs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Time step, set length and frame select
   always_comb begin
      sum_wide = {2'b00, elapsed_ff[DIV_W-2:0]} + {2'b00, req_data.time_step};
      if (elapsed_ff[DIV_W-1]) begin
         sum_wide = sum_wide + (DIV_W+1)'(1 << (DIV_W-1));
      end
      sum     = sum_wide[DIV_W-1:0];
      do_step = (req_data.time_step != '0) && (frame_period_ff != '0);
      over    = sum > {1'b0, frame_period_ff};
      area    = 20'(sheet_columns_ff) * 20'(sheet_rows_ff);
      if (active_set_ff == '0) begin
         len_now = (area > 20'(SET_DEPTH)) ? LEN_BITS'(SET_DEPTH) : area[LEN_BITS-1:0];
      end else begin
         len_now = set_length_ff[active_set_ff];
      end
      pos_inc = {1'b0, set_position_ff} + 1'b1;
      if ({1'b0, set_position_ff} >= len_ff) begin
         frame_sel = '0;
      end else if (active_set_ff == '0) begin
         frame_sel = FRAME_BITS'(set_position_ff);
      end else begin
         frame_sel = mem_rd_ff;
      end
      mem_we = accept && (req_data.mode == MODE_WRITE) && (req_data.set_number != '0);
      mem_wa = {req_data.set_number, req_data.position};
      mem_ra = {active_set_ff, set_position_ff};
   end

   // Sequencer and divider commands
   always_comb begin
      state_in        = state_ff;
      div_req.start    = 1'b0;
      div_req.nbits    = '0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_ADVANCE: begin
                     if (do_step && over) begin
                        div_req.start    = 1'b1;
                        div_req.nbits    = DIV_CNT_W'(DIV_W);
                        div_req.dividend = sum;
                        div_req.divisor  = frame_period_ff;
                        state_in        = S_EMOD;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  MODE_DRAW: begin
                     if (sheet_columns_ff != '0) begin
                        div_req.start    = 1'b1;
                        div_req.nbits    = DIV_CNT_W'(FRAME_BITS);
                        div_req.dividend = DIV_W'(req_data.frame_number);
                        div_req.divisor  = DIVISOR_W'(sheet_columns_ff);
                        state_in        = S_FDIV;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_EMOD: begin
            if (div_rsp.done) begin
               if (len_ff != '0) begin
                  div_req.start    = 1'b1;
                  div_req.nbits    = DIV_CNT_W'(LEN_BITS);
                  div_req.dividend = DIV_W'(pos_inc);
                  div_req.divisor  = DIVISOR_W'(len_ff);
                  state_in        = S_PMOD;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_PMOD: begin
            if (div_rsp.done) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: state_in = S_FRAME;
         S_FRAME: begin
            if (sheet_columns_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.nbits    = DIV_CNT_W'(FRAME_BITS);
               div_req.dividend = DIV_W'(frame_sel);
               div_req.divisor  = DIVISOR_W'(sheet_columns_ff);
               state_in        = S_FDIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FDIV: begin
            if (div_rsp.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Setup registers, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         frame_period_ff  <= '0;
         active_set_ff    <= '0;
         sheet_columns_ff <= 10'd1;
         sheet_rows_ff    <= 10'd1;
         frame_width_ff   <= '0;
         frame_height_ff  <= '0;
         elapsed_ff       <= '0;
         set_position_ff  <= '0;
         for (int i = 0; i < NUM_SETS; i++) begin
            set_length_ff[i] <= '0;
         end
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_FRAME_PERIOD:  frame_period_ff  <= csr_wdata;
               REG_ACTIVE_SET:    active_set_ff    <= csr_wdata[SET_BITS-1:0];
               REG_SHEET_COLUMNS: sheet_columns_ff <= csr_wdata[9:0];
               REG_SHEET_ROWS:    sheet_rows_ff    <= csr_wdata[9:0];
               REG_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[9:0];
               REG_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[9:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_data.mode)
                     MODE_ADVANCE: begin
                        if (do_step && !over) begin
                           elapsed_ff <= sum;
                        end
                     end
                     MODE_SET_POS: set_position_ff <= req_data.position;
                     MODE_WRITE: begin
                        if (req_data.set_number != '0 && req_data.is_last) begin
                           set_length_ff[req_data.set_number] <=
                              {1'b0, req_data.position} + 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_EMOD: begin
               if (div_rsp.done) begin
                  elapsed_ff <= DIV_W'(div_rsp.remainder);
                  if (len_ff == '0) begin
                     set_position_ff <= '0;
                  end
               end
            end
            S_PMOD: begin
               if (div_rsp.done) begin
                  set_position_ff <= div_rsp.remainder[POS_BITS-1:0];
               end
            end
            default: ;
         endcase
         // Result register: load when free, drop once taken
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-transaction work registers and result payload
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            len_ff   <= len_now;
            adv_ff   <= 1'b0;
            res_x_ff <= '0;
            res_y_ff <= '0;
            frame_ff <= (req_data.mode == MODE_DRAW) ? req_data.frame_number : '0;
         end
         S_EMOD: begin
            if (div_rsp.done) begin
               adv_ff <= 1'b1;
            end
         end
         S_FRAME: frame_ff <= frame_sel;
         S_FDIV: begin
            if (div_rsp.done) begin
               res_x_ff <= 20'(div_rsp.remainder[FRAME_BITS-1:0]) * 20'(frame_width_ff);
               res_y_ff <= 20'(div_rsp.quotient[FRAME_BITS-1:0]) * 20'(frame_height_ff);
            end
         end
         default: ;
      endcase
      if (state_ff == S_DONE && out_free) begin
         rsp_data_ff.sheet_x      <= res_x_ff;
         rsp_data_ff.sheet_y      <= res_y_ff;
         rsp_data_ff.frame_shown  <= frame_ff;
         rsp_data_ff.position_now <= set_position_ff;
         rsp_data_ff.advanced     <= adv_ff;
      end
   end

   // Frame set memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[mem_wa] <= req_data.frame_number;
      end
      mem_rd_ff <= set_mem[mem_ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `SFS_ASSERT_NEXT(a_accept_then_busy, clock, reset, accept, req_stall)
   `SFS_ASSERT_SAME(a_wrap_len_nonzero, clock, reset, state_ff == S_PMOD, len_ff != '0)
   `SFS_ASSERT_SAME(a_div_done_expected, clock, reset, div_rsp.done,
                    state_ff == S_EMOD || state_ff == S_PMOD || state_ff == S_FDIV)

endmodule

>>> tb/tb_sprite_frame_sequencer_unit.sv
// Self-checking testbench for the sprite frame sequencer unit.
`timescale 1ns / 100ps

module tb_sprite_frame_sequencer_unit;
   import sfs_pkg::*;

   localparam int REQ_W = $bits(req_type);

   // Mirror of the sequencer: registers, animation state and frame sets.
   // Every accepted request queues the one result it must produce.
   class frame_offset_scoreboard;
      logic [15:0] period = '0;
      logic [2:0]  aset   = '0;
      logic [9:0]  cols   = 10'd1;
      logic [9:0]  rows   = 10'd1;
      logic [9:0]  fw     = '0;
      logic [9:0]  fh     = '0;
      logic [16:0] elapsed = '0;
      logic [5:0]  cur_pos = '0;
      logic [9:0]  frames [0:7][0:63];
      int          set_len [0:7] = '{default: 0};
      rsp_type     expected_q [$];
      int          mismatches = 0;
      int          unexpected = 0;
      int          checked    = 0;
      int          advances   = 0;

      function void write_reg(logic [2:0] idx, logic [15:0] value);
         case (idx)
            REG_FRAME_PERIOD:  period = value;
            REG_ACTIVE_SET:    aset   = value[2:0];
            REG_SHEET_COLUMNS: cols   = value[9:0];
            REG_SHEET_ROWS:    rows   = value[9:0];
            REG_FRAME_WIDTH:   fw     = value[9:0];
            REG_FRAME_HEIGHT:  fh     = value[9:0];
            default: ;
         endcase
      endfunction

      // Set zero is the identity set, sized by the sheet and capped at the depth
      function int active_len();
         int n;
         if (aset == 3'd0) begin
            n = int'(cols) * int'(rows);
            return (n > SET_DEPTH) ? SET_DEPTH : n;
         end
         return set_len[aset];
      endfunction

      function void sheet_offsets(inout rsp_type e, input logic [9:0] f);
         e.frame_shown = f;
         if (cols != 0) begin
            e.sheet_x = 20'(f % cols) * 20'(fw);
            e.sheet_y = 20'(f / cols) * 20'(fh);
         end
      endfunction

      function void note_request(req_type r);
         rsp_type    e;
         int         len;
         logic [9:0] f;
         e = '0;
         case (r.mode)
            MODE_ADVANCE: begin
               // zero step or zero period leaves time and position alone
               if (r.time_step != 0 && period != 0) begin
                  elapsed = elapsed + 17'(r.time_step);
                  if (elapsed > 17'(period)) begin
                     len = active_len();
                     elapsed = elapsed % 17'(period);
                     cur_pos = (len != 0) ? 6'((int'(cur_pos) + 1) % len) : 6'd0;
                     e.advanced = 1'b1;
                     advances++;
                  end
               end
               len = active_len();
               if (cur_pos >= len)
                  f = '0;
               else if (aset == 3'd0)
                  f = 10'(cur_pos);
               else
                  f = frames[aset][cur_pos];
               sheet_offsets(e, f);
            end
            MODE_DRAW: sheet_offsets(e, r.frame_number);
            MODE_SET_POS: cur_pos = r.position;
            default: begin
               // set zero is fixed, writes to it are dropped
               if (r.set_number != 0) begin
                  frames[r.set_number][r.position] = r.frame_number;
                  if (r.is_last)
                     set_len[r.set_number] = int'(r.position) + 1;
               end
            end
         endcase
         e.position_now = cur_pos;
         expected_q.insert(expected_q.size(), e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected result transaction x=%0d y=%0d frame=%0d pos=%0d adv=%0d",
                        a.sheet_x, a.sheet_y, a.frame_shown, a.position_now, a.advanced);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (a.sheet_x !== e.sheet_x || a.sheet_y !== e.sheet_y ||
             a.frame_shown !== e.frame_shown || a.position_now !== e.position_now ||
             a.advanced !== e.advanced) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $display("mismatch on result %0d: expected x=%0d y=%0d frame=%0d pos=%0d adv=%0d",
                        checked, e.sheet_x, e.sheet_y, e.frame_shown, e.position_now,
                        e.advanced);
               $display("   got x=%0d y=%0d frame=%0d pos=%0d adv=%0d",
                        a.sheet_x, a.sheet_y, a.frame_shown, a.position_now, a.advanced);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int failures();
         return mismatches + unexpected + expected_q.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   frame_offset_scoreboard sb = new;
   bit entry_written [0:7][0:63];
   bit no_idle = 1'b0;
   int issued  = 0;
   int setups  = 0;

   sprite_frame_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 11);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_response(rsp_data);
   end

   // A set may only be closed once every entry below its end holds a frame
   function automatic bit prefix_written(logic [2:0] s, logic [5:0] p);
      for (int i = 0; i < p; i++)
         if (!entry_written[s][i])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic req_type random_req(logic [1:0] mode);
      req_type r;
      r = REQ_W'({$urandom, $urandom});
      r.mode = mode;
      return r;
   endfunction

   // Time steps around the period so that advances happen often
   function automatic logic [15:0] pick_step();
      int lim;
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: begin
            lim = int'(sb.period) + int'(sb.period) / 2 + 1;
            return 16'($urandom_range(0, (lim > 65535) ? 65535 : lim));
         end
      endcase
   endfunction

   // Drive one request transaction and note it once accepted
   task automatic send_request(input req_type r);
      if (r.mode == MODE_WRITE && r.set_number != 0) begin
         if (r.is_last && !prefix_written(r.set_number, r.position))
            r.is_last = 1'b0;
         entry_written[r.set_number][r.position] = 1'b1;
      end
      while (!no_idle && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      issued++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // New register setup, only once the block has drained
   task automatic configure(input logic [15:0] period, input logic [2:0] aset,
                            input logic [9:0] cols, input logic [9:0] rows,
                            input logic [9:0] fw, input logic [9:0] fh);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      write_csr(REG_FRAME_PERIOD, period);
      write_csr(REG_ACTIVE_SET, aset);
      write_csr(REG_SHEET_COLUMNS, cols);
      write_csr(REG_SHEET_ROWS, rows);
      write_csr(REG_FRAME_WIDTH, fw);
      write_csr(REG_FRAME_HEIGHT, fh);
      csr_wr_en <= 1'b0;
      setups++;
   endtask

   task automatic send_field(input logic [1:0] mode, input logic [15:0] step,
                             input logic [9:0] frame, input logic [2:0] set_num,
                             input logic [5:0] pos, input logic last);
      req_type r;
      r = random_req(mode);
      r.time_step    = step;
      r.frame_number = frame;
      r.set_number   = set_num;
      r.position     = pos;
      r.is_last      = last;
      send_request(r);
   endtask

   // Mostly set builds followed by animation, with some loose traffic mixed in
   task automatic random_phase(input int count);
      int      stop_at;
      int      n;
      int      k;
      int      pick;
      logic [2:0] s;
      req_type r;
      stop_at = issued + count;
      while (issued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            if (sb.aset == 3'd0 || $urandom_range(0, 4) == 0)
               s = 3'($urandom_range(1, 7));
            else
               s = sb.aset;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
            for (int p = 0; p < n; p++) begin
               r = random_req(MODE_WRITE);
               r.set_number = s;
               r.position   = 6'(p);
               r.is_last    = (p == n - 1);
               send_request(r);
            end
            if ($urandom_range(0, 1) == 0) begin
               r = random_req(MODE_SET_POS);
               r.position = 6'($urandom_range(0, n - 1));
               send_request(r);
            end
         end else if (pick < 80) begin
            k = $urandom_range(1, 12);
            for (int i = 0; i < k; i++) begin
               r = random_req(MODE_ADVANCE);
               r.time_step = pick_step();
               send_request(r);
            end
         end else begin
            case ($urandom_range(0, 2))
               0: r = random_req(MODE_DRAW);
               1: r = random_req(MODE_SET_POS);
               default: r = random_req(MODE_WRITE);
            endcase
            send_request(r);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 4x3 sheet of full-size frames on the identity set
      configure(16'd5, 3'd0, 10'd4, 10'd3, 10'd1023, 10'd1023);
      send_field(MODE_DRAW, 16'd0, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_DRAW, 16'hFFFF, 10'd1023, 3'd7, 6'd63, 1'b1);
      send_field(MODE_DRAW, 16'd0, 10'd3, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd0, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd5, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd1, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'hFFFF, 10'h3FF, 3'd7, 6'd63, 1'b1);
      send_field(MODE_SET_POS, 16'd0, 10'd0, 3'd0, 6'd63, 1'b0);
      send_field(MODE_ADVANCE, 16'd0, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd6, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_WRITE, 16'd0, 10'd7, 3'd0, 6'd5, 1'b1);
      send_field(MODE_WRITE, 16'd0, 10'd1023, 3'd7, 6'd0, 1'b0);
      send_field(MODE_WRITE, 16'd0, 10'd512, 3'd7, 6'd1, 1'b1);
      send_field(MODE_WRITE, 16'd0, 10'd0, 3'd1, 6'd63, 1'b1);

      // Directed: written set with zero columns, then an empty set
      configure(16'd1, 3'd7, 10'd0, 10'd1023, 10'd1023, 10'd1023);
      send_field(MODE_SET_POS, 16'd0, 10'd0, 3'd0, 6'd1, 1'b0);
      send_field(MODE_ADVANCE, 16'd0, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd2, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd3, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_DRAW, 16'd0, 10'd1023, 3'd0, 6'd0, 1'b0);
      configure(16'd3, 3'd6, 10'd1, 10'd1, 10'd9, 10'd9);
      send_field(MODE_ADVANCE, 16'd4, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_ADVANCE, 16'd1, 10'd0, 3'd0, 6'd0, 1'b0);
      send_field(MODE_DRAW, 16'd0, 10'd5, 3'd0, 6'd0, 1'b0);

      // Random phases, the first few at register extremes
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: configure(16'd1, 3'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
            1: configure(16'hFFFF, 3'd3, 10'd1, 10'd0, 10'd0, 10'd1023);
            2: configure(16'd0, 3'd5, 10'd7, 10'd9, 10'd16, 10'd16);
            3: configure(16'($urandom_range(2, 40)), 3'd0, 10'd0, 10'd5, 10'd1023, 10'd1023);
            4: configure(16'd8, 3'd2, 10'd5, 10'd5, 10'd32, 10'd24);
            default: configure(16'($urandom_range(1, 300)), 3'($urandom_range(0, 7)),
                               10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                               : $urandom_range(1, 12)),
                               10'($urandom_range(0, 12)), 10'($urandom), 10'($urandom));
         endcase
         no_idle = (ph == 4);
         random_phase(172);
      end
      no_idle = 1'b0;

      // Drain
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d result transactions over %0d register setups, %0d frame advances",
               sb.checked, setups, sb.advances);
      if (sb.failures() == 0)
         $display("tb_sprite_frame_sequencer_unit passed");
      else
         $display("tb_sprite_frame_sequencer_unit failed");
      $finish;
   end

   // Watchdog
   initial begin
      #12_000_000;
      $display("tb_sprite_frame_sequencer_unit failed");
      $finish;
   end

endmodule
